// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is active.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsmt_pkg.sv =====
// ---------------------------------------------------------------------------
// rsmt_pkg
// Types and codes shared by the response string matcher modules.
// ---------------------------------------------------------------------------
package rsmt_pkg;

  // Pattern storage fixed by the two 64-bit pattern registers.
  localparam int PAT_BYTES = 16;
  localparam int LEN_W     = 5;
  localparam int TMO_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 64;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

  localparam logic [LEN_W-1:0] PAT_LEN_RST = 5'd2;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd3000;
  localparam logic [TMO_W-1:0] TICKS_MAX   = 16'hFFFF;

  // Request opcodes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Search phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SEARCH  = 2'd1;
  localparam logic [1:0] PH_FOUND   = 2'd2;
  localparam logic [1:0] PH_TIMEOUT = 2'd3;

  // Reported status codes.
  localparam logic [1:0] ST_BUSY      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_TMO_DATA  = 2'd2;
  localparam logic [1:0] ST_TMO_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] received_count;
  } rsp_t;

  // Pattern prepared for the window compare: lane j holds the byte expected
  // at window position j (position 0 is the newest byte).
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pat_al;
    logic [PAT_BYTES-1:0]      lane_en;
    logic [LEN_W-1:0]          eff_len;
    logic                      empty;
    logic [TMO_W-1:0]          timeout;
  } match_cfg_t;

endpackage

// ===== rtl/rsmt_cfg.sv =====
// ---------------------------------------------------------------------------
// rsmt_cfg
// Configuration registers; derives the aligned compare pattern on each write.
// ---------------------------------------------------------------------------
module rsmt_cfg import rsmt_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  output match_cfg_t           mcfg_o
);

  // Reset pattern starts with a zero byte: empty effective pattern.
  localparam match_cfg_t MCFG_RST = '{
    pat_al:  '0,
    lane_en: '0,
    eff_len: '0,
    empty:   1'b1,
    timeout: TIMEOUT_RST
  };

  logic [63:0]      pat_lo_q, pat_lo_d;
  logic [63:0]      pat_hi_q, pat_hi_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [TMO_W-1:0] tmo_d;
  match_cfg_t       mcfg_q, mcfg_d;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_d    = len_q;
    tmo_d    = mcfg_q.timeout;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_LOW:  pat_lo_d = cfg_wdata_i;
        CFG_PAT_HIGH: pat_hi_d = cfg_wdata_i;
        CFG_PAT_LEN:  len_d    = cfg_wdata_i[LEN_W-1:0];
        CFG_TIMEOUT:  tmo_d    = cfg_wdata_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length, cut it at the first zero byte, then reverse the
  // pattern so lane j lines up with window position j.
  always_comb begin
    logic [PAT_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          n_clamp;
    logic [LEN_W-1:0]          eff;
    logic [LEN_W-1:0]          idx;
    bytes   = {pat_hi_d, pat_lo_d};
    n_clamp = (32'(len_d) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : len_d;
    eff     = n_clamp;
    for (int i = PAT_BYTES - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < n_clamp) && (bytes[i] == 8'h00)) begin
        eff = LEN_W'(i);
      end
    end
    mcfg_d         = '0;
    mcfg_d.eff_len = eff;
    mcfg_d.empty   = (eff == '0);
    mcfg_d.timeout = tmo_d;
    for (int j = 0; j < PAT_BYTES; j++) begin
      idx = eff - LEN_W'(j) - LEN_W'(1);
      mcfg_d.lane_en[j] = (LEN_W'(j) < eff);
      mcfg_d.pat_al[j]  = mcfg_d.lane_en[j] ? bytes[idx[3:0]] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= PAT_LEN_RST;
      mcfg_q   <= MCFG_RST;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      len_q    <= len_d;
      mcfg_q   <= mcfg_d;
    end
  end

  assign mcfg_o = mcfg_q;

endmodule

// ===== rtl/rsmt_match.sv =====
// ---------------------------------------------------------------------------
// rsmt_match
// Parallel compare of the shifted byte window against the aligned pattern.
// ---------------------------------------------------------------------------
module rsmt_match import rsmt_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic [PATTERN_MAX-1:0][7:0] win_i,
  input  match_cfg_t                  mcfg_i,
  output logic                        hit_o
);

  logic [PATTERN_MAX-1:0] lane_ok;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    assign lane_ok[j] = !mcfg_i.lane_en[j] || (win_i[j] == mcfg_i.pat_al[j]);
  end

  assign hit_o = &lane_ok;

endmodule

// ===== rtl/response_string_matcher_timeout.sv =====
// ---------------------------------------------------------------------------
// response_string_matcher_timeout
// Streaming search for a configured response string with a tick timeout.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | request   | in_valid_i / in_stall_o  | in_data_i  (opcode, byte)
//  out     | result    | out_valid_o / out_stall_i| out_data_o (status, count)
//  cfg     | write     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// Throughput is one request per cycle while in_stall_o is low; each result
// enters the output register as its request is taken. The window compare in
// rsmt_match and the state update sit between the search registers and the
// output register. in_stall_o is raised only while a result waits and the
// sink stalls. Reset clears all control state at once; there is no clearing
// pass. Config writes take effect for the request taken on the next edge.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module response_string_matcher_timeout import rsmt_pkg::*; #(
  parameter int BUFFER_BYTES = 256,
  parameter int PATTERN_MAX  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsp_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i
);

  // Kept-byte counter holds up to BUFFER_BYTES-1.
  localparam int KEEP_W = (BUFFER_BYTES > 2) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [KEEP_W-1:0] KEEP_MAX = KEEP_W'(BUFFER_BYTES - 1);

  match_cfg_t mcfg;

  logic [1:0]                  phase_q, phase_d;
  logic [KEEP_W-1:0]           kept_q, kept_d;
  logic                        ended_q, ended_d;
  logic [TMO_W-1:0]            elapsed_q, elapsed_d;
  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [PATTERN_MAX-1:0][7:0] win_shift;

  logic out_valid_q, out_valid_d;
  rsp_t rsp_q, rsp_d;

  logic in_acc;
  logic hit;
  logic [KEEP_W-1:0] kept_inc;
  logic kept_enough;

  rsmt_cfg #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mcfg_o     (mcfg)
  );

  // Window as it would look with the incoming byte pushed in as newest.
  always_comb begin
    win_shift[0] = in_data_i.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_shift[j] = win_q[j-1];
    end
  end

  rsmt_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .win_i (win_shift),
    .mcfg_i(mcfg),
    .hit_o (hit)
  );

  // Accept whenever the output register is free or being emptied now.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign kept_inc    = kept_q + KEEP_W'(1);
  assign kept_enough = (32'(kept_inc) >= 32'(mcfg.eff_len));

  // Next search state for the request being taken.
  always_comb begin
    logic added;
    logic [TMO_W-1:0] el;
    logic [31:0] kept_w;
    added     = 1'b0;
    el        = elapsed_q;
    phase_d   = phase_q;
    kept_d    = kept_q;
    ended_d   = ended_q;
    elapsed_d = elapsed_q;
    win_d     = win_q;
    if (in_acc) begin
      case (in_data_i.opcode)
        OP_START: begin
          win_d     = '0;
          kept_d    = '0;
          ended_d   = 1'b0;
          elapsed_d = '0;
          phase_d   = (mcfg.timeout == '0) ? PH_TIMEOUT : PH_SEARCH;
        end
        OP_BYTE: begin
          if (phase_q == PH_SEARCH) begin
            if (elapsed_q >= mcfg.timeout) begin
              // Out of time: drop the byte and give up.
              phase_d = PH_TIMEOUT;
            end else begin
              if (kept_q < KEEP_MAX) begin
                kept_d = kept_inc;
                if (!ended_q) begin
                  if (in_data_i.data_byte == 8'h00) begin
                    ended_d = 1'b1;
                  end else begin
                    win_d = win_shift;
                    added = 1'b1;
                  end
                end
              end
              if (mcfg.empty || (added && hit && kept_enough)) begin
                phase_d = PH_FOUND;
              end
            end
          end
        end
        OP_TICK: begin
          if (phase_q == PH_SEARCH) begin
            if (elapsed_q != TICKS_MAX) begin
              el = elapsed_q + TMO_W'(1);
            end
            elapsed_d = el;
            if (el >= mcfg.timeout) begin
              phase_d = PH_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end

    kept_w = 32'(kept_d);
    rsp_d.received_count = (kept_w > 32'd255) ? 8'hFF : kept_w[7:0];
    case (phase_d)
      PH_FOUND:   rsp_d.status = ST_FOUND;
      PH_TIMEOUT: rsp_d.status = (kept_d != '0) ? ST_TMO_DATA : ST_TMO_EMPTY;
      default:    rsp_d.status = ST_BUSY;
    endcase
  end

  // Load a fresh result on accept; drop the held one once taken.
  assign out_valid_d = in_acc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kept_q      <= '0;
      ended_q     <= 1'b0;
      elapsed_q   <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      kept_q      <= kept_d;
      ended_q     <= ended_d;
      elapsed_q   <= elapsed_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // A match needs at least one kept byte.
  `ASSERT_IMPL(a_found_has_bytes, clk_i, rst_ni, phase_q == PH_FOUND, kept_q != '0, "found without kept bytes")
  // A kept zero byte is counted.
  `ASSERT_IMPL(a_ended_has_bytes, clk_i, rst_ni, ended_q, kept_q != '0, "text ended with no bytes kept")
  // Every taken request leaves a result in the output register.
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_valid_o, "request taken without result")
  // A start with a nonzero timeout arms the search.
  `ASSERT_NEXT(a_start_arms, clk_i, rst_ni, in_acc && (in_data_i.opcode == OP_START) && (mcfg.timeout != '0), phase_q == PH_SEARCH, "start did not arm search")

endmodule

// ===== verif/response_string_matcher_timeout_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// response_string_matcher_timeout_test
// Self-checking bench for the streaming response string matcher. A tracker
// class mirrors the search state and the pattern registers, predicts one
// report per accepted request, and checks each report the block returns.
// ---------------------------------------------------------------------------
module response_string_matcher_timeout_test import rsmt_pkg::*; ();

  localparam int BUFFER_BYTES = 256;
  localparam int PATTERN_MAX  = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 40;
  localparam int LONG_BYTES   = 270;
  localparam int SHOW_LIMIT   = 20;

  // Opcode with no meaning: the block reports its current status.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // -------------------------------------------------------------------------
  // Search tracker: mirrors the registers and the search, holds the reports
  // still awaited from the block, and tallies what the run went through.
  // -------------------------------------------------------------------------
  class match_tracker;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic [15:0] tmo_lim;

    logic [7:0]  window [PATTERN_MAX];
    int unsigned kept;
    bit          ended;
    logic [15:0] ticks;
    logic [1:0]  phase;

    rsp_t awaited [$];

    int errors;
    int accepted;
    int searches;
    int reg_writes;
    int found_hits;
    int tmo_data_hits;
    int tmo_empty_hits;
    int dropped;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = PAT_LEN_RST;
      tmo_lim = TIMEOUT_RST;
      foreach (window[i]) window[i] = '0;
      kept  = 0;
      ended = 0;
      ticks = '0;
      phase = PH_IDLE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      reg_writes++;
      case (idx)
        CFG_PAT_LOW:  pat_lo  = v;
        CFG_PAT_HIGH: pat_hi  = v;
        CFG_PAT_LEN:  pat_len = v[LEN_W-1:0];
        CFG_TIMEOUT:  tmo_lim = v[TMO_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int i);
      if (i < 8) return pat_lo[8*i +: 8];
      return pat_hi[8*(i-8) +: 8];
    endfunction

    // Pattern in use: clamp the length, then cut it at the first zero byte.
    function int live_length();
      int n;
      n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      for (int i = 0; i < n; i++)
        if (pattern_byte(i) == 8'h00) return i;
      return n;
    endfunction

    function void take_request(req_t r);
      rsp_t       want;
      logic [1:0] was;
      int         n;
      bit         added;
      bit         hit;
      was = phase;
      accepted++;
      case (r.opcode)
        OP_START: begin
          foreach (window[i]) window[i] = '0;
          kept  = 0;
          ended = 0;
          ticks = '0;
          phase = (tmo_lim == '0) ? PH_TIMEOUT : PH_SEARCH;
          searches++;
        end
        OP_BYTE: begin
          if (phase == PH_SEARCH) begin
            n     = live_length();
            added = 0;
            if (ticks >= tmo_lim) begin
              // Timeout lowered under a running search: the byte is not kept.
              phase = PH_TIMEOUT;
            end else begin
              if (kept < BUFFER_BYTES - 1) begin
                kept++;
                if (!ended) begin
                  if (r.data_byte == 8'h00) begin
                    ended = 1;
                  end else begin
                    for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
                    window[0] = r.data_byte;
                    added = 1;
                  end
                end
              end else begin
                dropped++;
              end
              hit = (n == 0) || (added && kept >= n);
              for (int i = 0; i < n; i++)
                if (window[n-1-i] != pattern_byte(i)) hit = 0;
              if (hit) phase = PH_FOUND;
            end
          end
        end
        OP_TICK: begin
          if (phase == PH_SEARCH) begin
            if (ticks != TICKS_MAX) ticks++;
            if (ticks >= tmo_lim) phase = PH_TIMEOUT;
          end
        end
        default: ;
      endcase

      if (phase != was || r.opcode == OP_START) begin
        if (phase == PH_FOUND) found_hits++;
        if (phase == PH_TIMEOUT) begin
          if (kept > 0) tmo_data_hits++;
          else tmo_empty_hits++;
        end
      end

      if (phase == PH_FOUND) want.status = ST_FOUND;
      else if (phase == PH_TIMEOUT) want.status = (kept > 0) ? ST_TMO_DATA : ST_TMO_EMPTY;
      else want.status = ST_BUSY;
      want.received_count = (kept > 255) ? 8'd255 : 8'(kept);
      awaited.push_back(want);
    endfunction

    function void check_report(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        if (errors < SHOW_LIMIT)
          $display("%0t: report with none awaited: expected nothing, got status %0d count %0d",
                   $time, got.status, got.received_count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        if (errors < SHOW_LIMIT)
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, got.status);
        errors++;
      end
      if (got.received_count !== want.received_count) begin
        if (errors < SHOW_LIMIT)
          $display("%0t: received_count mismatch: expected %0d, got %0d",
                   $time, want.received_count, got.received_count);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // -------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  req_t                 in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rsp_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;

  // Shared between the request side and the result side.
  bit steady    = 1'b0;  // no idling on either side while set
  int hold_asks = 0;     // bumped by the request side to ask for a long hold-off

  match_tracker tracker = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  response_string_matcher_timeout #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .PATTERN_MAX (PATTERN_MAX)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // -------------------------------------------------------------------------
  // Request side helpers.
  // -------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it; then idle at
  // random unless the steady stretch is on.
  task automatic offer(input logic [1:0] op, input logic [7:0] b);
    req_t r;
    r.opcode    = op;
    r.data_byte = b;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_request(r);
    if (!steady && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every awaited report is back; the block
  // answers every request, so the wait comes to an end.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all four registers back to back. Spare upper bits of the narrow
  // registers carry random values; the block must mask them off.
  task automatic write_regs(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [15:0] lim);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [63:0]          vals [4];
    idx  = '{CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN, CFG_TIMEOUT};
    vals = '{lo, hi, {$urandom(), 27'($urandom()), len}, {$urandom(), 16'($urandom()), lim}};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      tracker.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Result side: stall at random, or hold off for a long stretch on request.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        // Hold off long enough for the block to fill and stall its input.
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 25);
      end
    end
  end

  // Check every report the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_report(out_data_o);
  end

  // -------------------------------------------------------------------------
  // Stimulus: directed cases first, then random searches.
  // -------------------------------------------------------------------------
  initial begin : requests
    int          base;
    int          round;
    int          body_len;
    int          sel;
    int          n;
    int          wait_cycles;
    bit          fresh_cfg;
    logic [127:0] pat;
    logic [4:0]  len;
    logic [15:0] lim;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle block: a byte and the spare opcode are ignored.
    offer(OP_BYTE, 8'h5A);
    offer(OP_SPARE, 8'hFF);
    // Reset pattern is all zero, so the pattern is empty: first byte is found.
    offer(OP_START, 8'h00);
    offer(OP_BYTE, 8'h00);
    offer(OP_BYTE, 8'hFF);

    // Pattern "AB", two ticks allowed.
    settle();
    write_regs(64'h4241, 64'h0, 5'd2, 16'd2);
    offer(OP_START, 8'hA5);
    offer(OP_BYTE, 8'h41);
    offer(OP_BYTE, 8'h42);
    // Ticks run out with nothing received.
    offer(OP_START, 8'h00);
    offer(OP_TICK, 8'hFF);
    offer(OP_TICK, 8'h00);
    // Lower the timeout under a running search: the next byte times out
    // and is not kept.
    offer(OP_START, 8'h00);
    offer(OP_BYTE, 8'h41);
    offer(OP_TICK, 8'h00);
    settle();
    write_regs(64'h4241, 64'h0, 5'd2, 16'd1);
    offer(OP_BYTE, 8'h42);
    // Zero timeout: a start gives up at once.
    settle();
    write_regs(64'h4241, 64'h0, 5'd2, 16'd0);
    offer(OP_START, 8'h33);
    // Zero byte inside the pattern cuts it to "AC"; oversize length clamps.
    settle();
    write_regs(64'h4400_4341, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 16'd500);
    offer(OP_START, 8'h00);
    offer(OP_BYTE, 8'h41);
    offer(OP_BYTE, 8'h43);
    // Zero byte in the text ends what can be searched.
    offer(OP_START, 8'h00);
    offer(OP_BYTE, 8'h00);
    offer(OP_BYTE, 8'h41);
    offer(OP_BYTE, 8'h43);

    base      = tracker.accepted;
    round     = 0;
    fresh_cfg = 1;
    while (tracker.accepted < base + RANDOM_ITEMS) begin
      steady <= (round >= 8 && round < 14);

      if (round == 5) begin
        // Overfill the buffer: the pattern bytes come after it is full and
        // must not match.
        settle();
        write_regs(64'h0003_0201, {$urandom(), $urandom()}, 5'd3, 16'hFFFF);
        offer(OP_START, 8'($urandom_range(255)));
        repeat (LONG_BYTES) offer(OP_BYTE, 8'($urandom_range(16, 255)));
        offer(OP_BYTE, 8'h01);
        offer(OP_BYTE, 8'h02);
        offer(OP_BYTE, 8'h03);
        offer(OP_TICK, 8'($urandom_range(255)));
        fresh_cfg = 1;
      end else begin
        if (fresh_cfg || $urandom_range(3) == 0) begin
          // Pick a new pattern and timeout, leaning to short patterns over a
          // small alphabet so that random text matches now and then.
          pat = {$urandom(), $urandom(), $urandom(), $urandom()};
          sel = $urandom_range(9);
          if (sel < 5)
            for (int i = 0; i < PATTERN_MAX; i++)
              pat[8*i +: 8] = 8'(8'h61 + $urandom_range(3));
          else if (sel == 9)
            pat[8*$urandom_range(PATTERN_MAX - 1) +: 8] = 8'h00;
          sel = $urandom_range(19);
          if (sel == 0) len = 5'd0;
          else if (sel == 1) len = 5'($urandom_range(17, 31));
          else if (sel < 4) len = 5'd16;
          else if (sel < 9) len = 5'($urandom_range(5, 15));
          else len = 5'($urandom_range(1, 4));
          sel = $urandom_range(9);
          if (sel < 3) lim = 16'($urandom_range(1, 8));
          else if (sel < 7) lim = 16'($urandom_range(10, 80));
          else if (sel == 7) lim = 16'd0;
          else if (sel == 8) lim = 16'hFFFF;
          else lim = 16'($urandom_range(65535));
          settle();
          write_regs(pat[63:0], pat[127:64], len, lim);
        end
        fresh_cfg = 0;

        // Ask for a long hold-off and keep offering through it.
        if (round == 3) hold_asks <= hold_asks + 1;

        offer(OP_START, 8'($urandom_range(255)));
        body_len = $urandom_range(1, 20);
        for (int k = 0; k < body_len; k++) begin
          sel = $urandom_range(99);
          if (sel < 12) begin
            // Whole pattern in one run.
            n = tracker.live_length();
            for (int i = 0; i < n; i++) offer(OP_BYTE, tracker.pattern_byte(i));
          end else if (sel < 30) offer(OP_TICK, 8'($urandom_range(255)));
          else if (sel < 35) offer(OP_BYTE, 8'h00);
          else if (sel < 38) offer(OP_SPARE, 8'($urandom_range(255)));
          else if (sel < 40) offer(OP_START, 8'($urandom_range(255)));
          else if (sel < 60)
            offer(OP_BYTE, tracker.pattern_byte($urandom_range(PATTERN_MAX - 1)));
          else if (sel < 80) offer(OP_BYTE, 8'(8'h61 + $urandom_range(3)));
          else offer(OP_BYTE, 8'($urandom_range(255)));
        end

        // Now and then cut the timeout under a live search.
        if (tracker.phase == PH_SEARCH && $urandom_range(7) == 0) begin
          settle();
          write_regs(tracker.pat_lo, tracker.pat_hi, tracker.pat_len,
                     16'($urandom_range(0, tracker.ticks)));
          offer($urandom_range(1) ? OP_BYTE : OP_TICK, 8'($urandom_range(255)));
          fresh_cfg = 1;
        end
      end
      round++;
    end

    // Drain: drop valid and wait for the last reports, with a limit.
    in_valid_i <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 1000 && tracker.awaited.size() != 0; wait_cycles++)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (tracker.awaited.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, tracker.awaited.size());
      tracker.errors += tracker.awaited.size();
    end

    $display("covered %0d requests in %0d searches with %0d register writes",
             tracker.accepted, tracker.searches, tracker.reg_writes);
    $display("outcomes: %0d found, %0d timed out with data, %0d timed out empty, %0d bytes dropped",
             tracker.found_hits, tracker.tmo_data_hits, tracker.tmo_empty_hits, tracker.dropped);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rsmt_pkg.sv
rtl/rsmt_cfg.sv
rtl/rsmt_match.sv
rtl/response_string_matcher_timeout.sv
verif/response_string_matcher_timeout_test.sv
